[rtl/psf_pkg.sv]
// Shared types and constants for the packed 12-bit pixel span fill core.
`default_nettype none
package psf_pkg;

  localparam int unsigned AddrBits      = 24;
  localparam int unsigned ColorBits     = 8;
  localparam int unsigned CountBits     = 8;
  localparam int unsigned DataBits      = 32;
  localparam int unsigned MaxSpanPixels = 128;
  localparam int unsigned QueueDepth    = 2;

  localparam logic [ColorBits-1:0] OddLowMask  = 8'h0F;
  localparam logic [ColorBits-1:0] RemHighMask = 8'hF0;
  localparam logic [1:0]           WordAlignMask = 2'h3;

  // classified span request handed from front to back
  typedef struct packed {
    logic [AddrBits-1:0]  addr;
    logic [AddrBits-1:0]  end_addr;
    logic [ColorBits-1:0] color;
    logic                 odd;
    logic [CountBits-1:0] fill_bytes;
    logic                 rem;
  } span_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ODD_OR,
    ST_ODD_ST,
    ST_FILL,
    ST_REM_ST,
    ST_REM_AND
  } back_state_e;

endpackage
`default_nettype wire

[rtl/packed_12bit_pixel_span_fill_core.sv]
// First write: with the queue empty, the first write is strobed once the request has passed
// the front register, the queue entry and the sequencer state; then one write per cycle to the span's end.
// Span length: at most 55 writes, for 128 pixels from an odd start; the back sequencer takes
// the next request only after a span's last write, and the write sequencer sets the rate.
// Requests are taken while busy is low; a two-entry queue holds requests ahead of the sequencer.
// Reset (async, active low) empties the front register and queue and idles the sequencer.
`default_nettype none
module packed_12bit_pixel_span_fill_core
  import psf_pkg::*;
#(
  parameter int unsigned MAX_SPAN_PIXELS = MaxSpanPixels
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [AddrBits-1:0]  start_address_i,
  input  wire logic                 odd_start_i,
  input  wire logic [ColorBits-1:0] fill_color_i,
  input  wire logic [CountBits-1:0] pixel_count_i,
  output logic                      write_valid_o,
  output logic [AddrBits-1:0]       write_address_o,
  output logic [DataBits-1:0]       write_data_o,
  output logic                      word_write_o,
  output logic                      merge_or_o,
  output logic [AddrBits-1:0]       end_address_o,
  output logic                      last_write_o
);

  logic      front_valid;
  logic      queue_ready;
  span_cmd_t front_cmd;
  logic      queue_valid;
  logic      queue_pop;
  span_cmd_t queue_cmd;

  psf_front #(
    .MAX_SPAN_PIXELS(MAX_SPAN_PIXELS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .start_address_i(start_address_i),
    .odd_start_i    (odd_start_i),
    .fill_color_i   (fill_color_i),
    .pixel_count_i  (pixel_count_i),
    .cmd_valid_o    (front_valid),
    .cmd_ready_i    (queue_ready),
    .cmd_o          (front_cmd)
  );

  psf_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (front_valid),
    .ready_o    (queue_ready),
    .push_data_i(front_cmd),
    .pop_i      (queue_pop),
    .valid_o    (queue_valid),
    .pop_data_o (queue_cmd)
  );

  psf_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (queue_valid),
    .cmd_i          (queue_cmd),
    .cmd_pop_o      (queue_pop),
    .write_valid_o  (write_valid_o),
    .write_address_o(write_address_o),
    .write_data_o   (write_data_o),
    .word_write_o   (word_write_o),
    .merge_or_o     (merge_or_o),
    .end_address_o  (end_address_o),
    .last_write_o   (last_write_o)
  );

endmodule
`default_nettype wire

[rtl/psf_front.sv]
// Front stage: takes span requests, clamps the count and precomputes byte counts and end address.
`default_nettype none
module psf_front
  import psf_pkg::*;
#(
  parameter int unsigned MAX_SPAN_PIXELS = MaxSpanPixels
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [AddrBits-1:0]  start_address_i,
  input  wire logic                 odd_start_i,
  input  wire logic [ColorBits-1:0] fill_color_i,
  input  wire logic [CountBits-1:0] pixel_count_i,
  output logic                      cmd_valid_o,
  input  wire logic                 cmd_ready_i,
  output span_cmd_t                 cmd_o
);

  localparam logic [CountBits-1:0] MaxCount = CountBits'(MAX_SPAN_PIXELS);

  logic                 valid_q, valid_d;
  span_cmd_t            cmd_q;
  logic                 accept;
  logic [CountBits-1:0] count_sat;
  logic [CountBits-1:0] count_rest;
  logic [CountBits-1:0] pair_bytes;
  span_cmd_t            cmd_new;

  assign busy   = valid_q && !cmd_ready_i;
  assign accept = start && !busy;

  always_comb begin
    count_sat  = (pixel_count_i > MaxCount) ? MaxCount : pixel_count_i;
    count_rest = count_sat - CountBits'(odd_start_i);
    // three bytes per whole pixel pair
    pair_bytes = {count_rest[CountBits-1:1], 1'b0} + {1'b0, count_rest[CountBits-1:1]};
    cmd_new.addr       = start_address_i;
    cmd_new.color      = fill_color_i;
    cmd_new.odd        = odd_start_i;
    cmd_new.fill_bytes = pair_bytes;
    cmd_new.rem        = count_rest[0];
    cmd_new.end_addr   = start_address_i + {{(AddrBits-2){1'b0}}, odd_start_i, 1'b0}
                         + AddrBits'(pair_bytes) + AddrBits'(count_rest[0]);
  end

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = (pixel_count_i != '0);
    end else if (valid_q && cmd_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_new;
    end
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

endmodule
`default_nettype wire

[rtl/psf_queue.sv]
// Short request queue between front and back.
`default_nettype none
module psf_queue
  import psf_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  output logic           ready_o,
  input  wire span_cmd_t push_data_i,
  input  wire logic      pop_i,
  output logic           valid_o,
  output span_cmd_t      pop_data_o
);

  localparam int unsigned PtrBits = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntBits = $clog2(QueueDepth + 1);
  localparam logic [PtrBits-1:0] LastIdx = PtrBits'(QueueDepth - 1);

  span_cmd_t            mem_q [QueueDepth];
  logic [PtrBits-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrBits-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0]   count_q, count_d;
  logic                 do_push, do_pop;

  assign ready_o    = (count_q != CntBits'(QueueDepth));
  assign valid_o    = (count_q != '0);
  assign do_push    = push_i && ready_o;
  assign do_pop     = pop_i && valid_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

[rtl/psf_back.sv]
// Back stage: walks one span request and emits one memory write per cycle while a span is in progress.
`default_nettype none
module psf_back
  import psf_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cmd_valid_i,
  input  wire span_cmd_t            cmd_i,
  output logic                      cmd_pop_o,
  output logic                      write_valid_o,
  output logic [AddrBits-1:0]       write_address_o,
  output logic [DataBits-1:0]       write_data_o,
  output logic                      word_write_o,
  output logic                      merge_or_o,
  output logic [AddrBits-1:0]       end_address_o,
  output logic                      last_write_o
);

  back_state_e          state_q, state_d;
  logic [AddrBits-1:0]  addr_q, addr_d;
  logic [AddrBits-1:0]  end_q, end_d;
  logic [ColorBits-1:0] color_q, color_d;
  logic [CountBits-1:0] bytes_q, bytes_d;
  logic                 rem_q, rem_d;
  logic                 do_word;
  logic [CountBits-1:0] bytes_after;

  // word store only once aligned and a full word is left
  assign do_word     = ((addr_q[1:0] & WordAlignMask) == 2'b00) && (bytes_q >= CountBits'(4));
  assign bytes_after = bytes_q - (do_word ? CountBits'(4) : CountBits'(1));

  // next state and datapath
  always_comb begin
    state_d   = state_q;
    addr_d    = addr_q;
    end_d     = end_q;
    color_d   = color_q;
    bytes_d   = bytes_q;
    rem_d     = rem_q;
    cmd_pop_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          addr_d    = cmd_i.addr;
          end_d     = cmd_i.end_addr;
          color_d   = cmd_i.color;
          bytes_d   = cmd_i.fill_bytes;
          rem_d     = cmd_i.rem;
          if (cmd_i.odd) begin
            state_d = ST_ODD_OR;
          end else if (cmd_i.fill_bytes != '0) begin
            state_d = ST_FILL;
          end else begin
            state_d = ST_REM_ST;
          end
        end
      end
      ST_ODD_OR: begin
        addr_d  = addr_q + 1'b1;
        state_d = ST_ODD_ST;
      end
      ST_ODD_ST: begin
        addr_d = addr_q + 1'b1;
        if (bytes_q != '0) begin
          state_d = ST_FILL;
        end else if (rem_q) begin
          state_d = ST_REM_ST;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_FILL: begin
        addr_d  = addr_q + (do_word ? AddrBits'(4) : AddrBits'(1));
        bytes_d = bytes_after;
        if (bytes_after == '0) begin
          state_d = rem_q ? ST_REM_ST : ST_IDLE;
        end
      end
      ST_REM_ST: begin
        addr_d  = addr_q + 1'b1;
        state_d = ST_REM_AND;
      end
      ST_REM_AND: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // write outputs
  always_comb begin
    write_valid_o   = 1'b1;
    write_address_o = addr_q;
    write_data_o    = DataBits'(color_q);
    word_write_o    = 1'b0;
    merge_or_o      = 1'b0;
    end_address_o   = end_q;
    last_write_o    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        write_valid_o = 1'b0;
      end
      ST_ODD_OR: begin
        write_data_o = DataBits'(color_q & OddLowMask);
        merge_or_o   = 1'b1;
      end
      ST_ODD_ST: begin
        last_write_o = (bytes_q == '0) && !rem_q;
      end
      ST_FILL: begin
        word_write_o = do_word;
        if (do_word) begin
          write_data_o = {4{color_q}};
        end
        last_write_o = (bytes_after == '0) && !rem_q;
      end
      ST_REM_ST: begin
      end
      ST_REM_AND: begin
        write_data_o = DataBits'(color_q & RemHighMask);
        last_write_o = 1'b1;
      end
      default: begin
        write_valid_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q  <= addr_d;
    end_q   <= end_d;
    color_q <= color_d;
    bytes_q <= bytes_d;
    rem_q   <= rem_d;
  end

endmodule
`default_nettype wire

[rtl/psf_chk.sv]
// Port-level checks for the span fill core, bound to the top level.
`default_nettype none
module psf_chk
  import psf_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 write_valid_o,
  input wire logic [AddrBits-1:0]  write_address_o,
  input wire logic [DataBits-1:0]  write_data_o,
  input wire logic                 word_write_o,
  input wire logic                 merge_or_o,
  input wire logic [AddrBits-1:0]  end_address_o,
  input wire logic                 last_write_o
);

  // word stores land on word boundaries and carry the colour in every byte
  a_word_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    write_valid_o && word_write_o |->
      (write_address_o[1:0] == 2'b00) &&
      (write_data_o[31:24] == write_data_o[7:0]) &&
      (write_data_o[23:16] == write_data_o[7:0]) &&
      (write_data_o[15:8] == write_data_o[7:0]))
    else $error("word write misaligned or not replicated");

  a_byte_upper_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    write_valid_o && !word_write_o |-> (write_data_o[31:8] == '0))
    else $error("byte write with upper data bits set");

  a_merge_nibble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    write_valid_o && merge_or_o |-> !word_write_o && !last_write_o &&
      (write_data_o[31:4] == '0))
    else $error("merge write malformed");

  // writes of one request come back to back with a fixed end address
  a_span_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    write_valid_o && !last_write_o |=> write_valid_o && $stable(end_address_o))
    else $error("gap or end address change inside a span");

endmodule

bind packed_12bit_pixel_span_fill_core psf_chk u_psf_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .write_valid_o  (write_valid_o),
  .write_address_o(write_address_o),
  .write_data_o   (write_data_o),
  .word_write_o   (word_write_o),
  .merge_or_o     (merge_or_o),
  .end_address_o  (end_address_o),
  .last_write_o   (last_write_o)
);
`default_nettype wire
